/* rtl/core/bitmap_frame_allocator_unit_macros.svh */
// Assertion macros used by the frame allocator unit.
`ifndef BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/bfa_pkg.sv */
// Package with the command and status codes and the bit search helper.
package bfa_pkg;

  localparam int WORD_BITS = 64;
  localparam int ADDR_W    = 28;

  typedef logic [2:0] cmd_t;
  typedef logic [1:0] status_t;

  localparam cmd_t CMD_TAKE    = 3'd0;
  localparam cmd_t CMD_RETURN  = 3'd1;
  localparam cmd_t CMD_RESERVE = 3'd2;
  localparam cmd_t CMD_ADD     = 3'd3;
  localparam cmd_t CMD_LIST    = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_NONE  = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

  function automatic logic [5:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = 6'(i);
      end
    end
    return r;
  endfunction

endpackage

/* rtl/core/bitmap_frame_allocator_unit.sv */
// Frame allocator: one request at a time walks the free bitmap a 64-bit memory word per step.
// After reset a clearing pass zeroes the bitmap word by word, and no request is
// taken until it ends. A request then holds the input stalled while a small sequencer walks
// the single-port bitmap memory. Return, reserve and add read, load and write back each word.
// Take and list also scan each loaded word before the write back, reporting the frames they
// find one at a time; list first reads each stored region to set its range. A stalled output
// holds the scan and the final result until it is taken.
module bitmap_frame_allocator_unit #(
  parameter int NUM_FRAMES   = 65536,
  parameter int FRAME_BYTES  = 4096,
  parameter int REGION_SLOTS = 32,
  parameter int MAX_BATCH    = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bfa_pkg::cmd_t        in_command,
  input  logic [27:0]          in_address,
  input  logic [28:0]          in_extent_bytes,
  input  logic [6:0]           in_count,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [27:0]          out_frame_address,
  output bfa_pkg::status_t     out_status,
  output logic                 out_last,
  output logic [6:0]           out_done_count
);
  import bfa_pkg::*;

  `include "bitmap_frame_allocator_unit_macros.svh"

  localparam int FW  = $clog2(NUM_FRAMES);
  localparam int FBW = $clog2(FRAME_BYTES);
  localparam int NW  = NUM_FRAMES / WORD_BITS;
  localparam int WW  = (NW > 1) ? $clog2(NW) : 1;
  localparam int RIW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam int CW  = $clog2(REGION_SLOTS + 1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RG   = 4'd2;
  localparam logic [3:0] S_RGW  = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_LD   = 4'd5;
  localparam logic [3:0] S_SCAN = 4'd6;
  localparam logic [3:0] S_WR   = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]           state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [6:0]           want_r, want_nxt;
  logic [6:0]           n_r, n_nxt;
  logic [FW-1:0]        first_r, first_nxt;
  logic [FW-1:0]        last_r, last_nxt;
  logic [WW-1:0]        word_r, word_nxt;
  logic [WORD_BITS-1:0] data_r, data_nxt;
  logic [WORD_BITS-1:0] cand_r, cand_nxt;
  logic [CW-1:0]        reg_idx_r, reg_idx_nxt;
  logic [CW-1:0]        region_count_r, region_count_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [27:0]          pend_addr_r, pend_addr_nxt;
  status_t              pend_status_r, pend_status_nxt;
  logic [6:0]           pend_done_r, pend_done_nxt;
  logic                 out_valid_r;
  logic [27:0]          out_addr_r;
  status_t              out_status_r;
  logic                 out_last_r;
  logic [6:0]           out_done_r;

  logic                 push;
  logic [27:0]          push_addr;
  status_t              push_status;
  logic                 push_last;
  logic [6:0]           push_done;
  logic                 can_push;

  logic                 map_we;
  logic [WORD_BITS-1:0] map_wdata;
  logic [WORD_BITS-1:0] map_rdata;
  logic                 reg_we;
  logic [RIW-1:0]       reg_addr;
  logic [2*FW-1:0]      reg_rdata;

  logic                 accept;
  logic [6:0]           want_cap;
  logic [31:0]          first_full;
  logic [29:0]          end_byte;
  logic [31:0]          last_full;
  logic [27:0]          addr_round;
  logic [WW-1:0]        word_first;
  logic [WW-1:0]        word_last;
  logic [WORD_BITS-1:0] mask;
  logic [5:0]           bit_idx;
  logic [FW-1:0]        found;
  logic [FW+27:0]       found_wide;
  logic                 batch_done;

  assign accept     = in_valid && (state_r == S_IDLE);
  assign in_stall   = (state_r != S_IDLE);
  assign can_push   = !out_valid_r || !out_stall;
  assign want_cap   = (in_count > 7'(MAX_BATCH)) ? 7'(MAX_BATCH) : in_count;
  assign first_full = 32'(in_address >> FBW);
  assign end_byte   = 30'(in_address) + 30'(in_extent_bytes) - 30'd1;
  assign last_full  = 32'(end_byte >> FBW);
  assign addr_round = in_address & ~28'(FRAME_BYTES - 1);
  assign word_first = WW'(first_r >> 6);
  assign word_last  = WW'(last_r >> 6);
  assign bit_idx    = lowest_set(cand_r);
  assign found      = FW'({word_r, bit_idx});
  assign found_wide = {28'd0, found} << FBW;
  assign batch_done = ((cmd_r == CMD_TAKE) || (cmd_r == CMD_LIST)) && (n_r == want_r);

  always_comb begin
    mask = '1;
    if (word_r == word_first) begin
      mask = mask & ({WORD_BITS{1'b1}} << first_r[5:0]);
    end
    if (word_r == word_last) begin
      mask = mask & ({WORD_BITS{1'b1}} >> (6'd63 - last_r[5:0]));
    end
  end

  assign map_we    = (state_r == S_CLR) || (state_r == S_WR);
  assign map_wdata = (state_r == S_CLR) ? '0 : data_r;
  assign reg_addr  = (state_r == S_IDLE) ? region_count_r[RIW-1:0] : reg_idx_r[RIW-1:0];

  always_comb begin
    state_nxt        = state_r;
    cmd_nxt          = cmd_r;
    want_nxt         = want_r;
    n_nxt            = n_r;
    first_nxt        = first_r;
    last_nxt         = last_r;
    word_nxt         = word_r;
    data_nxt         = data_r;
    cand_nxt         = cand_r;
    reg_idx_nxt      = reg_idx_r;
    region_count_nxt = region_count_r;
    pend_valid_nxt   = pend_valid_r;
    pend_addr_nxt    = pend_addr_r;
    pend_status_nxt  = pend_status_r;
    pend_done_nxt    = pend_done_r;
    reg_we           = 1'b0;
    push             = 1'b0;
    push_addr        = pend_addr_r;
    push_status      = pend_status_r;
    push_last        = 1'b0;
    push_done        = pend_done_r;
    case (state_r)
      S_CLR: begin
        word_nxt = word_r + WW'(1);
        if (word_r == WW'(NW - 1)) begin
          word_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_nxt         = in_command;
          want_nxt        = want_cap;
          n_nxt           = '0;
          pend_valid_nxt  = 1'b0;
          pend_addr_nxt   = addr_round;
          pend_status_nxt = ST_OK;
          pend_done_nxt   = '0;
          first_nxt       = FW'(first_full);
          last_nxt        = FW'(first_full);
          word_nxt        = WW'(first_full >> 6);
          reg_idx_nxt     = '0;
          state_nxt       = S_FIN;
          case (in_command)
            CMD_TAKE: begin
              first_nxt = '0;
              last_nxt  = FW'(NUM_FRAMES - 1);
              word_nxt  = '0;
              if (want_cap != 7'd0) begin
                state_nxt = S_RD;
              end
            end
            CMD_RETURN: begin
              pend_valid_nxt = 1'b1;
              if (first_full >= 32'(NUM_FRAMES)) begin
                pend_status_nxt = ST_RANGE;
              end else begin
                state_nxt = S_RD;
              end
            end
            CMD_RESERVE, CMD_ADD: begin
              pend_valid_nxt = 1'b1;
              last_nxt       = FW'(last_full);
              if (in_extent_bytes == 29'd0) begin
                pend_status_nxt = ST_OK;
              end else if (last_full >= 32'(NUM_FRAMES)) begin
                pend_status_nxt = ST_RANGE;
              end else if ((in_command == CMD_ADD) && (region_count_r == CW'(REGION_SLOTS))) begin
                pend_status_nxt = ST_FULL;
              end else begin
                if (in_command == CMD_ADD) begin
                  reg_we           = 1'b1;
                  region_count_nxt = region_count_r + CW'(1);
                end
                state_nxt = S_RD;
              end
            end
            CMD_LIST: begin
              if ((want_cap != 7'd0) && (region_count_r != '0)) begin
                state_nxt = S_RG;
              end
            end
            default: begin
              // An unknown command reports nothing found.
              want_nxt = 7'd1;
            end
          endcase
        end
      end
      S_RG: begin
        state_nxt = S_RGW;
      end
      S_RGW: begin
        first_nxt = reg_rdata[2*FW-1:FW];
        last_nxt  = reg_rdata[FW-1:0];
        word_nxt  = WW'(reg_rdata[2*FW-1:FW] >> 6);
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_LD;
      end
      S_LD: begin
        data_nxt  = map_rdata;
        cand_nxt  = '0;
        state_nxt = S_WR;
        case (cmd_r)
          CMD_TAKE: begin
            cand_nxt  = map_rdata & mask;
            state_nxt = S_SCAN;
          end
          CMD_LIST: begin
            cand_nxt  = ~map_rdata & mask;
            state_nxt = S_SCAN;
          end
          CMD_RESERVE: begin
            data_nxt = map_rdata & ~mask;
          end
          default: begin
            data_nxt = map_rdata | mask;
          end
        endcase
      end
      S_SCAN: begin
        if ((cand_r == '0) || (n_r == want_r)) begin
          state_nxt = S_WR;
        end else if (!pend_valid_r || can_push) begin
          push                   = pend_valid_r;
          pend_valid_nxt         = 1'b1;
          pend_addr_nxt          = found_wide[27:0];
          pend_status_nxt        = ST_OK;
          pend_done_nxt          = n_r + 7'd1;
          n_nxt                  = n_r + 7'd1;
          cand_nxt[bit_idx]      = 1'b0;
          if (cmd_r == CMD_TAKE) begin
            data_nxt[bit_idx] = 1'b0;
          end
        end
      end
      S_WR: begin
        if ((word_r == word_last) || batch_done) begin
          state_nxt = S_FIN;
          if ((cmd_r == CMD_LIST) && !batch_done &&
              (({1'b0, reg_idx_r} + (CW+1)'(1)) < {1'b0, region_count_r})) begin
            reg_idx_nxt = reg_idx_r + CW'(1);
            state_nxt   = S_RG;
          end
        end else begin
          word_nxt  = word_r + WW'(1);
          state_nxt = S_RD;
        end
      end
      S_FIN: begin
        if (can_push) begin
          push      = 1'b1;
          push_last = 1'b1;
          if (!pend_valid_r) begin
            push_addr   = '0;
            push_status = (want_r == 7'd0) ? ST_OK : ST_NONE;
            push_done   = '0;
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLR;
      word_r         <= '0;
      n_r            <= '0;
      want_r         <= '0;
      region_count_r <= '0;
      pend_valid_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      word_r         <= word_nxt;
      n_r            <= n_nxt;
      want_r         <= want_nxt;
      region_count_r <= region_count_nxt;
      pend_valid_r   <= pend_valid_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    first_r       <= first_nxt;
    last_r        <= last_nxt;
    data_r        <= data_nxt;
    cand_r        <= cand_nxt;
    reg_idx_r     <= reg_idx_nxt;
    pend_addr_r   <= pend_addr_nxt;
    pend_status_r <= pend_status_nxt;
    pend_done_r   <= pend_done_nxt;
    if (push) begin
      out_addr_r   <= push_addr;
      out_status_r <= push_status;
      out_last_r   <= push_last;
      out_done_r   <= push_done;
    end
  end

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NW)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .addr  (word_r),
    .wdata (map_wdata),
    .rdata (map_rdata)
  );

  bfa_ram #(
    .WIDTH (2 * FW),
    .DEPTH (REGION_SLOTS)
  ) u_regions (
    .clk   (clk),
    .we    (reg_we),
    .addr  (reg_addr),
    .wdata ({FW'(first_full), FW'(last_full)}),
    .rdata (reg_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_frame_address = out_addr_r;
  assign out_status        = out_status_r;
  assign out_last          = out_last_r;
  assign out_done_count    = out_done_r;

  `BFA_ASSERT_NOW(a_batch_bound, 1'b1, n_r <= want_r, "frames reported exceed the batch size")
  `BFA_ASSERT_NOW(a_region_bound, 1'b1, region_count_r <= CW'(REGION_SLOTS), "region count overflow")
  `BFA_ASSERT_NOW(a_no_write_idle, state_r == S_IDLE, !map_we, "bitmap written while idle")
  `BFA_ASSERT_NEXT(a_clear_ends, (state_r == S_CLR) && (word_r == WW'(NW - 1)), state_r == S_IDLE, "clearing pass did not end")

endmodule

/* rtl/core/bfa_ram.sv */
// Generic single-port RAM with registered read data.
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* tb/sv/tb_bitmap_frame_allocator_unit.sv */
// Self-checking testbench for the bitmap frame allocator with a behavioural allocator model.
module tb_bitmap_frame_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bfa_pkg::*;

  localparam int NFRAMES = 65536;
  localparam int FBYTES = 4096;
  localparam int NSLOTS = 32;
  localparam int BATCH = 64;
  localparam int LIMIT = 8000000;

  typedef struct packed {
    logic [27:0] frame_address;
    status_t     status;
    logic        last;
    logic [6:0]  done_count;
  } grant_t;

  typedef struct {
    cmd_t        command;
    logic [27:0] address;
    logic [28:0] extent_bytes;
    logic [6:0]  count;
    logic        fixed;
    grant_t      answer;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cmd_t in_command = CMD_TAKE;
  logic [27:0] in_address = '0;
  logic [28:0] in_extent_bytes = '0;
  logic [6:0] in_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [27:0] out_frame_address;
  status_t out_status;
  logic out_last;
  logic [6:0] out_done_count;

  bit free_bits [NFRAMES];
  int unsigned zone_lo [NSLOTS];
  int unsigned zone_hi [NSLOTS];
  int unsigned zone_used;
  grant_t pending_grants [$];
  request_t directed [$];
  int errors = 0;
  int cycles = 0;
  int granted = 0;
  int sent = 0;
  bit hold_off = 1'b0;

  bitmap_frame_allocator_unit dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL bitmap_frame_allocator_unit");
      $finish;
    end
  end

  function automatic grant_t mk(int unsigned frame, status_t st, logic lst, int unsigned done);
    grant_t g;
    g.frame_address = 28'(frame * FBYTES);
    g.status = st;
    g.last = lst;
    g.done_count = 7'(done);
    return g;
  endfunction

  task automatic allocate_predict(input request_t r);
    int unsigned want, n, first, lastf;
    longint unsigned ending;
    want = (r.count > BATCH) ? BATCH : r.count;
    n = 0;
    first = r.address / FBYTES;
    case (r.command)
      CMD_TAKE, CMD_LIST: begin
        if (r.command == CMD_TAKE) begin
          for (int f = 0; f < NFRAMES && n < want; f++) begin
            if (free_bits[f]) begin
              free_bits[f] = 1'b0;
              n++;
              pending_grants.push_back(mk(f, ST_OK, 1'b0, n));
            end
          end
        end else begin
          for (int z = 0; z < zone_used; z++) begin
            for (int f = zone_lo[z]; f <= zone_hi[z] && n < want; f++) begin
              if (!free_bits[f]) begin
                n++;
                pending_grants.push_back(mk(f, ST_OK, 1'b0, n));
              end
            end
          end
        end
        if (n > 0) pending_grants[$].last = 1'b1;
        else pending_grants.push_back(mk(0, want == 0 ? ST_OK : ST_NONE, 1'b1, 0));
      end
      CMD_RETURN: begin
        if (first >= NFRAMES) begin
          pending_grants.push_back(mk(first, ST_RANGE, 1'b1, 0));
        end else begin
          free_bits[first] = 1'b1;
          pending_grants.push_back(mk(first, ST_OK, 1'b1, 0));
        end
      end
      CMD_RESERVE, CMD_ADD: begin
        ending = longint'(r.address) + longint'(r.extent_bytes) - 1;
        lastf = int'(ending / FBYTES);
        if (r.extent_bytes == 0) begin
          pending_grants.push_back(mk(first, ST_OK, 1'b1, 0));
        end else if (ending / FBYTES >= NFRAMES) begin
          pending_grants.push_back(mk(first, ST_RANGE, 1'b1, 0));
        end else if (r.command == CMD_ADD && zone_used >= NSLOTS) begin
          pending_grants.push_back(mk(first, ST_FULL, 1'b1, 0));
        end else begin
          if (r.command == CMD_ADD) begin
            zone_lo[zone_used] = first;
            zone_hi[zone_used] = lastf;
            zone_used++;
          end
          for (int f = first; f <= lastf; f++) free_bits[f] = (r.command == CMD_ADD);
          pending_grants.push_back(mk(first, ST_OK, 1'b1, 0));
        end
      end
      default: pending_grants.push_back(mk(0, ST_NONE, 1'b1, 0));
    endcase
  endtask

  task automatic send(input request_t r);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= r.command;
    in_address <= r.address;
    in_extent_bytes <= r.extent_bytes;
    in_count <= r.count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    allocate_predict(r);
    if (r.fixed) pending_grants[$] = r.answer;
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  function automatic request_t rq(cmd_t c, int unsigned a, int unsigned e, int unsigned n);
    request_t r;
    r.command = c;
    r.address = 28'(a);
    r.extent_bytes = 29'(e);
    r.count = 7'(n);
    r.fixed = 1'b0;
    r.answer = '0;
    return r;
  endfunction

  function automatic request_t rk(cmd_t c, int unsigned a, int unsigned e, int unsigned n,
                                  grant_t g);
    request_t r;
    r = rq(c, a, e, n);
    r.fixed = 1'b1;
    r.answer = g;
    return r;
  endfunction

  function automatic request_t rand_request();
    int unsigned k, base, len;
    k = $urandom_range(0, 99);
    base = $urandom_range(0, 255) * FBYTES + ($urandom_range(0, 1) ? $urandom_range(0, 4095) : 0);
    if ($urandom_range(0, 15) == 0) base = $urandom;
    len = $urandom_range(1, 6 * FBYTES);
    if ($urandom_range(0, 19) == 0) len = $urandom & 29'h1FFFFFFF;
    if ($urandom_range(0, 19) == 0) len = 0;
    if (k < 25) return rq(CMD_TAKE, $urandom, 0, $urandom_range(0, 127));
    if (k < 45) return rq(CMD_RETURN, $urandom_range(0, 1) ? base : $urandom, $urandom, 0);
    if (k < 60) return rq(CMD_RESERVE, base, len, $urandom);
    if (k < 75) return rq(CMD_ADD, base, len, $urandom);
    if (k < 95) return rq(CMD_LIST, $urandom, $urandom, $urandom_range(0, 127));
    return rq(cmd_t'($urandom_range(5, 7)), $urandom, $urandom, $urandom);
  endfunction

  always @(posedge clk) begin
    grant_t got, exp_g;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_frame_address, out_status, out_last, out_done_count};
      granted++;
      if (pending_grants.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_g = pending_grants.pop_front();
        if (got.frame_address !== exp_g.frame_address)
          $display("%0t frame_address exp %h got %h", $time, exp_g.frame_address,
                   got.frame_address);
        if (got.status !== exp_g.status)
          $display("%0t status exp %0d got %0d", $time, exp_g.status, got.status);
        if (got.last !== exp_g.last)
          $display("%0t last exp %0d got %0d", $time, exp_g.last, got.last);
        if (got.done_count !== exp_g.done_count)
          $display("%0t done_count exp %0d got %0d", $time, exp_g.done_count, got.done_count);
        if (got !== exp_g) errors++;
      end
    end
  end

  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        hold = 0;
        while (hold < 400) begin
          @(posedge clk);
          hold++;
        end
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 19) == 0 ? $urandom_range(10, 50) : $urandom_range(1, 3))
          @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    for (int f = 0; f < NFRAMES; f++) free_bits[f] = 1'b0;
    zone_used = 0;
    directed.push_back(rk(CMD_TAKE, 0, 0, 5, mk(0, ST_NONE, 1'b1, 0)));
    directed.push_back(rk(CMD_LIST, 0, 0, 64, mk(0, ST_NONE, 1'b1, 0)));
    directed.push_back(rk(CMD_TAKE, 0, 0, 0, mk(0, ST_OK, 1'b1, 0)));
    directed.push_back(rk(CMD_RETURN, 28'hFFFFFFF, 0, 0, mk(28'hFFFF, ST_OK, 1'b1, 0)));
    directed.push_back(rk(CMD_ADD, 0, 0, 0, mk(0, ST_OK, 1'b1, 0)));
    directed.push_back(rk(CMD_RESERVE, 28'hFFFFFFF, 29'h10000000, 0,
                          mk(28'hFFFF, ST_RANGE, 1'b1, 0)));
    directed.push_back(rk(CMD_ADD, 28'hFFFF000, 29'h1000, 0, mk(28'hFFFF, ST_OK, 1'b1, 0)));
    directed.push_back(rk(cmd_t'(3'd7), 28'hFFFFFFF, 29'h1FFFFFFF, 7'h7F,
                          mk(0, ST_NONE, 1'b1, 0)));
    directed.push_back(rq(CMD_ADD, 4096, 3 * FBYTES + 1, 0));
    directed.push_back(rq(CMD_LIST, 0, 0, 10));
    directed.push_back(rq(CMD_TAKE, 0, 0, 2));
    directed.push_back(rq(CMD_LIST, 0, 0, 127));
    directed.push_back(rq(CMD_RETURN, 4096 + 77, 0, 0));
    directed.push_back(rq(CMD_RETURN, 4096 + 77, 0, 0));
    directed.push_back(rq(CMD_RESERVE, 8192 + 5, 4096, 0));
    directed.push_back(rq(CMD_ADD, 0, 29'h10000000, 0));
    directed.push_back(rq(CMD_TAKE, 0, 0, 127));
    directed.push_back(rq(CMD_LIST, 0, 0, 64));
    directed.push_back(rq(cmd_t'(3'd5), 0, 0, 0));
    for (int i = 0; i < 29; i++) directed.push_back(rq(CMD_ADD, i * FBYTES, FBYTES, 0));
    directed.push_back(rq(CMD_ADD, 0, FBYTES, 0));
    directed.push_back(rq(CMD_RETURN, 0, 0, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) send(directed[i]);
    wait_drained();

    hold_off = 1'b1;
    for (int i = 0; i < 8; i++) send(rq(CMD_TAKE, 0, 0, 64));
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      for (int f = 0; f < NFRAMES; f++) free_bits[f] = free_bits[f];
      for (int i = 0; i < 40; i++) send(rand_request());
      wait_drained();
    end
    repeat (200) @(posedge clk);

    $display("Covered %0d requests and %0d results: take, return, reserve, add, list,",
             sent, granted);
    $display("unknown codes, range and table-full errors, with stalls on both sides.");
    if (errors == 0) begin
      $display("PASS bitmap_frame_allocator_unit");
    end else begin
      $display("FAIL bitmap_frame_allocator_unit");
    end
    $finish;
  end
endmodule
